[design/bfs_pkg.sv]
// Shared constants, request codes and controller/datapath interface types
// for the bitmap find-set/free unit. No dependencies.
package bfs_pkg;

  localparam int MAP_BITS  = 4096;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int POS_W     = ADDR_W + OFF_W;
  localparam int CNT_W     = POS_W + 1;
  localparam int NW_W      = ADDR_W + 1;
  localparam int PADDR_W   = 3;

  localparam logic [PADDR_W-1:0] REG_BITS_IN_USE = 3'd0;

  localparam logic [2:0] REQ_SET       = 3'd0;
  localparam logic [2:0] REQ_CLEAR     = 3'd1;
  localparam logic [2:0] REQ_TEST      = 3'd2;
  localparam logic [2:0] REQ_NEXT_SET  = 3'd3;
  localparam logic [2:0] REQ_PREV_SET  = 3'd4;
  localparam logic [2:0] REQ_NEXT_FREE = 3'd5;
  localparam logic [2:0] REQ_PREV_FREE = 3'd6;
  localparam logic [2:0] REQ_UNUSED    = 3'd7;

  typedef struct packed {
    logic load;
    logic rd_first;
    logic eval;
    logic step;
    logic fail;
  } bfs_cmd_t;

  typedef struct packed {
    logic ok;
    logic is_search;
    logic hit;
    logic last;
  } bfs_stat_t;

  function automatic logic [OFF_W-1:0] low_one(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = OFF_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] high_one(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) begin
        r = OFF_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[design/bitmap_find_set_free_unit.sv]
// Top level of the bitmap find-set/free unit: configuration register,
// controller and datapath. Depends on bfs_pkg, bfs_regs, bfs_ctrl and bfs_dp.
//
// Channel   Signals                                       Handshake
// request   start, req_type, position                     start && !busy
// result    done, status, found_position, bit_value,      done, one cycle
//           set_count
// config    psel, penable, pwrite, paddr, pwdata, prdata  APB, pready tied high
//
// A request that is out of range, or carries the unused code, goes from the check
// state straight to the result state; set, clear and test pass through the scan
// state once. A search reads one 64-bit word per cycle from the single memory
// read port until a hit or the last word in use. One request is handled at
// a time; busy is high from acceptance through the result cycle, so the next
// request is accepted in the cycle after the result at the earliest. Reset clears
// the bitmap at once through per-word valid bits, so no clearing pass is needed.
module bitmap_find_set_free_unit import bfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic [POS_W-1:0]   position,
  output logic               done,
  output logic               status,
  output logic [POS_W-1:0]   found_position,
  output logic               bit_value,
  output logic [CNT_W-1:0]   set_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CNT_W-1:0] bits_in_use;
  bfs_cmd_t         cmd;
  bfs_stat_t        stat;

  bfs_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .bits_in_use (bits_in_use)
  );

  bfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bfs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (req_type),
    .position       (position),
    .bits_in_use    (bits_in_use),
    .status         (status),
    .found_position (found_position),
    .bit_value      (bit_value),
    .set_count      (set_count)
  );

endmodule

[design/bfs_regs.sv]
// APB-style configuration register holding the number of bit positions in use.
// Depends on bfs_pkg.
module bfs_regs import bfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [CNT_W-1:0]   bits_in_use
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= CNT_W'(MAP_BITS);
    end else if (psel && penable && pwrite && pready && paddr == REG_BITS_IN_USE) begin
      bits_in_use <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr == REG_BITS_IN_USE) ? {{(32 - CNT_W){1'b0}}, bits_in_use} : '0;

endmodule

[design/bfs_ctrl.sv]
// Controller state machine sequencing request checks, word reads and results.
// Depends on bfs_pkg.
module bfs_ctrl import bfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  bfs_stat_t stat,
  output bfs_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.ok) begin
          cmd.rd_first = 1'b1;
          state_next   = S_SCAN;
        end else begin
          cmd.fail   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.eval = 1'b1;
        if (stat.is_search && !stat.hit && !stat.last) begin
          cmd.step = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

[design/bfs_dp.sv]
// Datapath: bitmap word memory with per-word valid bits, set counter, word
// scan logic and result registers. Depends on bfs_pkg.
module bfs_dp import bfs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  bfs_cmd_t         cmd,
  output bfs_stat_t        stat,
  input  logic [2:0]       req_type,
  input  logic [POS_W-1:0] position,
  input  logic [CNT_W-1:0] bits_in_use,
  output logic             status,
  output logic [POS_W-1:0] found_position,
  output logic             bit_value,
  output logic [CNT_W-1:0] set_count
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_bits;
  logic [WORD_BITS-1:0] rdata;
  logic                 rvalid;

  logic [2:0]       type_q;
  logic [POS_W-1:0] pos_q;
  logic [CNT_W-1:0] limit_q;
  logic [ADDR_W-1:0] idx;
  logic              first;
  logic [CNT_W-1:0]  ones_count;

  logic [CNT_W-1:0]     limit_sum;
  logic [NW_W-1:0]      nwords;
  logic [OFF_W-1:0]     off;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] scan_v;
  logic                 forward;
  logic                 want_set;
  logic                 cur_bit;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wdata;
  logic [POS_W-1:0]     hit_pos;

  assign limit_sum = limit_q + CNT_W'(WORD_BITS - 1);
  assign nwords    = limit_sum[CNT_W-1:OFF_W];
  assign off       = pos_q[OFF_W-1:0];
  assign word      = rvalid ? rdata : '0;
  assign bit_sel   = {{(WORD_BITS - 1){1'b0}}, 1'b1} << off;
  assign cur_bit   = |(word & bit_sel);
  assign forward   = (type_q == REQ_NEXT_SET) || (type_q == REQ_NEXT_FREE);
  assign want_set  = (type_q == REQ_NEXT_SET) || (type_q == REQ_PREV_SET);

  always_comb begin
    if (!first) begin
      mask = '1;
    end else if (forward) begin
      mask = {WORD_BITS{1'b1}} << off;
    end else begin
      mask = {WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - off);
    end
  end

  assign scan_v  = (want_set ? word : ~word) & mask;
  assign hit_pos = {idx, (forward ? low_one(scan_v) : high_one(scan_v))};

  assign stat.ok        = ({1'b0, pos_q} < limit_q) && (type_q != REQ_UNUSED);
  assign stat.is_search = (type_q == REQ_NEXT_SET) || (type_q == REQ_PREV_SET) ||
                          (type_q == REQ_NEXT_FREE) || (type_q == REQ_PREV_FREE);
  assign stat.hit       = |scan_v;
  assign stat.last      = forward ? (({1'b0, idx} + NW_W'(1)) >= nwords) : (idx == '0);

  assign rd_en   = cmd.rd_first || cmd.step;
  assign rd_addr = cmd.rd_first ? pos_q[POS_W-1:OFF_W] :
                   (forward ? idx + ADDR_W'(1) : idx - ADDR_W'(1));

  assign wr_en = cmd.eval && (((type_q == REQ_SET) && !cur_bit) ||
                              ((type_q == REQ_CLEAR) && cur_bit));
  assign wdata = (type_q == REQ_SET) ? (word | bit_sel) : (word & ~bit_sel);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rvalid     <= 1'b0;
      ones_count <= '0;
    end else begin
      if (wr_en) begin
        valid_bits[idx] <= 1'b1;
        ones_count      <= (type_q == REQ_SET) ? ones_count + CNT_W'(1)
                                               : ones_count - CNT_W'(1);
      end
      if (rd_en) begin
        rvalid <= valid_bits[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_q  <= req_type;
      pos_q   <= position;
      limit_q <= (bits_in_use > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : bits_in_use;
    end
    if (rd_en) begin
      idx   <= rd_addr;
      first <= cmd.rd_first;
    end
    if (cmd.fail) begin
      status         <= 1'b1;
      found_position <= '0;
      bit_value      <= 1'b0;
    end else if (cmd.eval) begin
      status         <= 1'b0;
      found_position <= '0;
      bit_value      <= 1'b0;
      if (type_q == REQ_TEST) begin
        bit_value <= cur_bit;
      end else if (stat.is_search) begin
        if (stat.hit && ({1'b0, hit_pos} < limit_q)) begin
          found_position <= hit_pos;
        end else begin
          status <= 1'b1;
        end
      end
    end
  end

  assign set_count = ones_count;

endmodule

[design/bfs_checker.sv]
// Port-level checker for the bitmap find-set/free unit, bound to the top level.
// Depends on bfs_pkg.
module bfs_checker import bfs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             status,
  input logic [POS_W-1:0] found_position,
  input logic             bit_value
);

  // The result strobe only appears while a request is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe without a request in flight");

  // An accepted request makes the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // The unit becomes free again right after the result cycle.
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy && !done)
    else $error("unit still busy after result");

  // A failed request reports neither a position nor a bit value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (found_position == '0 && !bit_value))
    else $error("no_resource result carries data");

endmodule

bind bitmap_find_set_free_unit bfs_checker u_bfs_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .status         (status),
  .found_position (found_position),
  .bit_value      (bit_value)
);

[bench/tb_bitmap_find_set_free_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_find_set_free_unit: drives set, clear, test, search and unused-code
// requests, keeps a shadow bitmap to predict every reply, and resizes the map over APB.
// Depends on bfs_pkg and the unit itself.
module tb_bitmap_find_set_free_unit;
  import bfs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 10;
  localparam int RANDOM_PER_PHASE = 45;

  typedef struct {
    logic [2:0]       kind;
    logic [POS_W-1:0] pos;
  } request_t;

  typedef struct packed {
    logic             status;
    logic [POS_W-1:0] found;
    logic             bit_val;
    logic [CNT_W-1:0] count;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         req_type = REQ_SET;
  logic [POS_W-1:0]   position = '0;
  logic               done;
  logic               status;
  logic [POS_W-1:0]   found_position;
  logic               bit_value;
  logic [CNT_W-1:0]   set_count;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = REG_BITS_IN_USE;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  logic [CNT_W-1:0]     shadow_count = '0;
  int unsigned          shadow_size = MAP_BITS;

  request_t    pending_requests[$];
  reply_t      expected_replies[$];
  request_t    next_request;
  reply_t      oldest_reply;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          gap_left = 0;
  bit          gaps_on = 1'b0;

  bitmap_find_set_free_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .position       (position),
    .done           (done),
    .status         (status),
    .found_position (found_position),
    .bit_value      (bit_value),
    .set_count      (set_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk = ~clk;

  initial begin
    foreach (shadow_map[i]) shadow_map[i] = '0;
  end

  function automatic reply_t apply_bitmap_request(input logic [2:0] kind,
                                                  input logic [POS_W-1:0] pos);
    reply_t               r;
    int                   limit;
    int                   nwords;
    int                   w;
    int                   off;
    int                   j;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] scan;
    bit                   searching;
    r.status  = 1'b1;
    r.found   = '0;
    r.bit_val = 1'b0;
    limit  = (shadow_size > MAP_BITS) ? MAP_BITS : shadow_size;
    nwords = (limit + WORD_BITS - 1) / WORD_BITS;
    w      = pos / WORD_BITS;
    off    = pos % WORD_BITS;
    if (pos < limit) begin
      case (kind)
        REQ_SET: begin
          if (!shadow_map[w][off]) begin
            shadow_map[w][off] = 1'b1;
            shadow_count = shadow_count + 1'b1;
          end
          r.status = 1'b0;
        end
        REQ_CLEAR: begin
          if (shadow_map[w][off]) begin
            shadow_map[w][off] = 1'b0;
            shadow_count = shadow_count - 1'b1;
          end
          r.status = 1'b0;
        end
        REQ_TEST: begin
          r.bit_val = shadow_map[w][off];
          r.status  = 1'b0;
        end
        REQ_NEXT_SET, REQ_NEXT_FREE: begin
          mask = {WORD_BITS{1'b1}} << off;
          searching = 1'b1;
          for (int k = w; k < nwords && searching; k++) begin
            scan = (kind == REQ_NEXT_SET) ? (shadow_map[k] & mask) : (~shadow_map[k] & mask);
            if (scan != '0) begin
              searching = 1'b0;
              j = 0;
              while (!scan[j]) j++;
              if (k * WORD_BITS + j < limit) begin
                r.status = 1'b0;
                r.found  = POS_W'(k * WORD_BITS + j);
              end
            end
            mask = {WORD_BITS{1'b1}};
          end
        end
        REQ_PREV_SET, REQ_PREV_FREE: begin
          mask = {WORD_BITS{1'b1}} >> (WORD_BITS - 1 - off);
          searching = 1'b1;
          for (int k = w; k >= 0 && searching; k--) begin
            scan = (kind == REQ_PREV_SET) ? (shadow_map[k] & mask) : (~shadow_map[k] & mask);
            if (scan != '0) begin
              searching = 1'b0;
              j = WORD_BITS - 1;
              while (!scan[j]) j--;
              if (k * WORD_BITS + j < limit) begin
                r.status = 1'b0;
                r.found  = POS_W'(k * WORD_BITS + j);
              end
            end
            mask = {WORD_BITS{1'b1}};
          end
        end
        default: begin
        end
      endcase
    end
    r.count = shadow_count;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(20, 4);
    return $urandom_range(90, 40);
  endfunction

  function automatic request_t random_request(input int unsigned limit, input int unsigned base,
                                              input int unsigned span);
    request_t    rq;
    int unsigned r;
    int          p;
    r = $urandom_range(99);
    if (r < 28) rq.kind = REQ_SET;
    else if (r < 40) rq.kind = REQ_CLEAR;
    else if (r < 48) rq.kind = REQ_TEST;
    else if (r < 60) rq.kind = REQ_NEXT_SET;
    else if (r < 72) rq.kind = REQ_PREV_SET;
    else if (r < 84) rq.kind = REQ_NEXT_FREE;
    else if (r < 96) rq.kind = REQ_PREV_FREE;
    else rq.kind = REQ_UNUSED;
    r = $urandom_range(99);
    if (r < 70) p = base + $urandom_range(span - 1);
    else if (r < 85) p = $urandom_range(MAP_BITS - 1);
    else if (r < 95) p = int'(limit) + $urandom_range(3) - 2;
    else p = $urandom_range(1) ? MAP_BITS - 1 : 0;
    if (p < 0) p = 0;
    if (p > MAP_BITS - 1) p = MAP_BITS - 1;
    rq.pos = POS_W'(p);
    return rq;
  endfunction

  task automatic queue_request(input logic [2:0] kind, input int unsigned pos);
    request_t rq;
    rq.kind = kind;
    rq.pos  = POS_W'(pos);
    pending_requests.push_back(rq);
    queued_cnt++;
  endtask

  task automatic wait_idle(input int settle);
    while (accepted_cnt != queued_cnt || expected_replies.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_BITS_IN_USE) shadow_size = data[CNT_W-1:0];
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_cnt, field, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_replies.push_back(apply_bitmap_request(req_type, position));
        accepted_cnt++;
        gap_left = gaps_on ? pick_gap() : 0;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        next_request = pending_requests.pop_front();
        start    <= 1'b1;
        req_type <= next_request.kind;
        position <= next_request.pos;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply, status", status, 0);
      end else begin
        oldest_reply = expected_replies.pop_front();
        if (status !== oldest_reply.status)
          report_mismatch("status", status, oldest_reply.status);
        if (found_position !== oldest_reply.found)
          report_mismatch("found_position", found_position, oldest_reply.found);
        if (bit_value !== oldest_reply.bit_val)
          report_mismatch("bit_value", bit_value, oldest_reply.bit_val);
        if (set_count !== oldest_reply.count)
          report_mismatch("set_count", set_count, oldest_reply.count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_bitmap_find_set_free_unit failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase_size [NUM_PHASES];
    int unsigned size;
    int unsigned limit;
    int unsigned base;
    int unsigned span;
    int unsigned fill_len;
    logic [31:0] wdata;
    phase_size = '{130, 0, 1, 64, 65, 8191, 4095, 4096, 200, 0};
    phase_size[NUM_PHASES-1] = $urandom_range(MAP_BITS);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_request(REQ_TEST, 0);
    queue_request(REQ_NEXT_SET, 0);
    queue_request(REQ_PREV_SET, MAP_BITS - 1);
    queue_request(REQ_NEXT_FREE, MAP_BITS - 1);
    queue_request(REQ_PREV_FREE, 0);
    queue_request(REQ_SET, 0);
    queue_request(REQ_SET, 0);
    queue_request(REQ_SET, MAP_BITS - 1);
    queue_request(REQ_SET, 63);
    queue_request(REQ_SET, 64);
    queue_request(REQ_TEST, MAP_BITS - 1);
    queue_request(REQ_NEXT_SET, 1);
    queue_request(REQ_NEXT_SET, 65);
    queue_request(REQ_PREV_SET, MAP_BITS - 2);
    queue_request(REQ_PREV_SET, 62);
    queue_request(REQ_CLEAR, 1);
    queue_request(REQ_CLEAR, 63);
    queue_request(REQ_NEXT_FREE, 0);
    queue_request(REQ_PREV_FREE, 64);
    queue_request(REQ_UNUSED, 5);
    queue_request(REQ_UNUSED, MAP_BITS - 1);
    queue_request(REQ_NEXT_SET, MAP_BITS - 1);
    queue_request(REQ_PREV_SET, 0);
    wait_idle(4);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      size  = phase_size[ph];
      wdata = $urandom();
      wdata[CNT_W-1:0] = size[CNT_W-1:0];
      write_reg(REG_BITS_IN_USE, wdata);
      limit   = (size > MAP_BITS) ? MAP_BITS : size;
      gaps_on = (ph % 3 != 2);
      base    = (limit == 0) ? 0 : $urandom_range(limit - 1);
      span    = ($urandom_range(2) == 0) ? $urandom_range(16, 1) : $urandom_range(256, 1);
      if (ph % 2 == 0 && limit >= WORD_BITS) begin
        base     = $urandom_range(limit / WORD_BITS - 1) * WORD_BITS;
        fill_len = $urandom_range(100, WORD_BITS);
        for (int unsigned p = base; p < base + fill_len && p < MAP_BITS; p++)
          queue_request(REQ_SET, p);
        queue_request(REQ_NEXT_FREE, base);
        queue_request(REQ_PREV_FREE, base + WORD_BITS - 1);
        queue_request(REQ_NEXT_SET, base);
        queue_request(REQ_PREV_SET, base + WORD_BITS - 1);
        span = fill_len + 8;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 25 == 24 && limit != 0) base = $urandom_range(limit - 1);
        pending_requests.push_back(random_request(limit, base, span));
        queued_cnt++;
      end
      wait_idle(4);
    end

    wait_idle(70);
    if (mismatch_cnt == 0 && expected_replies.size() == 0) begin
      $display("tb_bitmap_find_set_free_unit passed");
    end else begin
      $display("tb_bitmap_find_set_free_unit failed");
    end
    $finish;
  end

endmodule

[bitmap_find_set_free_unit.f]
design/bfs_pkg.sv
design/bfs_regs.sv
design/bfs_ctrl.sv
design/bfs_dp.sv
design/bitmap_find_set_free_unit.sv
design/bfs_checker.sv
bench/tb_bitmap_find_set_free_unit.sv
